// ===== hdl/sdre_pkg.sv =====
// ----------------------------------------------------------------------------
// sdre_pkg
// Shared types and constants for the signed radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdre_pkg;

  // Alphabet storage: eight 64-bit words of byte symbols
  localparam int unsigned NUM_WORDS     = 8;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned WORD_SEL_BITS = 3;
  localparam int unsigned SYM_BITS      = 8;
  localparam int unsigned IDX_BITS      = 6;
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned SEEN_BITS     = 128;

  // Character codes
  localparam logic [SYM_BITS-1:0] SYM_LO     = 8'd33;
  localparam logic [SYM_BITS-1:0] SYM_HI     = 8'd126;
  localparam logic [SYM_BITS-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_BITS-1:0] CHAR_NONE  = 8'h00;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : sdre_pkg

`default_nettype wire

// ===== hdl/sdre_divider.sv =====
// ----------------------------------------------------------------------------
// sdre_divider
// Restoring divider, one quotient bit per cycle, shared by all digits.
// ----------------------------------------------------------------------------
`default_nettype none

module sdre_divider
  import sdre_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned RAD_BITS   = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [RAD_BITS-1:0]   divisor_i,
  output      logic [VALUE_BITS-1:0] quotient_o,
  output      logic [RAD_BITS-1:0]   remainder_o,
  output      div_stat_t             stat_o
);

  localparam int unsigned CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_q;
  logic [RAD_BITS-1:0]   rem_q;
  logic [RAD_BITS-1:0]   div_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [RAD_BITS:0]     trial;
  logic                  fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= CW'(VALUE_BITS - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= RAD_BITS'(trial - {1'b0, div_q});
        end else begin
          rem_q <= trial[RAD_BITS-1:0];
        end
        quo_q <= {quo_q[VALUE_BITS-2:0], fits};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o      = '{busy: busy_q, done: done_q};

endmodule : sdre_divider

`default_nettype wire

// ===== hdl/sdre_digit_stack.sv =====
// ----------------------------------------------------------------------------
// sdre_digit_stack
// Digit store: digits go in least significant first and are read back in
// reverse, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdre_digit_stack
  import sdre_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule : sdre_digit_stack

`default_nettype wire

// ===== hdl/signed_radix_digit_emitter_core.sv =====
// Flow: the request is accepted, the alphabet is scanned, then each digit comes from the
// shared divider, then the sign (if negative) and the digit characters are shown, each
// held while the output is stalled. One request at a time: the next is taken the
// cycle after the last result leaves. Reset clears the alphabet to zero (an invalid
// alphabet, so each request returns a single bad_base result) and idles the sequencer.
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_core
// Converts a signed value to text in the radix given by a configured alphabet.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_digit_emitter_core
  import sdre_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 64,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Configuration writes
  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [WORD_BITS-1:0]    cfg_data_i,
  // Input requests
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic signed [31:0]      value_i,
  // Results
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [7:0]              out_char_o,
  output      logic                    bad_base_o,
  output      logic                    is_last_o
);

  localparam int unsigned RW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned DW = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned NW = $clog2(VALUE_BITS + 1);
  localparam int unsigned AW = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DSTART,
    ST_DWAIT,
    ST_READ,
    ST_LOAD,
    ST_SHOW
  } state_e;

  // Alphabet registers
  logic [NUM_WORDS-1:0][WORD_BITS-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_BITS'(NUM_WORDS))) begin
      alpha_q[cfg_index_i[WORD_SEL_BITS-1:0]] <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Sequencer registers
  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [RW-1:0]         scan_q, scan_d;
  logic [RW-1:0]         radix_q, radix_d;
  logic [SEEN_BITS-1:0]  seen_q, seen_d;
  logic [NW-1:0]         nd_q, nd_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  bad_base_q, bad_base_d;
  logic                  is_last_q, is_last_d;

  // Shared units
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_quo;
  logic [RW-1:0]         div_rem;
  div_stat_t             div_stat;
  logic                  stk_wr;
  logic                  stk_rd;
  logic [NW-1:0]         nd_m1;
  logic [DW-1:0]         stk_data;
  logic [IDX_BITS-1:0]   sym_idx;
  logic [SYM_BITS-1:0]   sym;
  logic [VALUE_BITS-1:0] in_bits;
  logic                  sym_bad;

  sdre_divider #(
    .VALUE_BITS (VALUE_BITS),
    .RAD_BITS   (RW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_q),
    .divisor_i   (radix_q),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  assign nd_m1  = nd_q - 1'b1;
  assign stk_wr = (state_q == ST_DWAIT) && div_stat.done;
  assign stk_rd = (state_q == ST_READ);

  sdre_digit_stack #(
    .DEPTH (VALUE_BITS),
    .WIDTH (DW)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (stk_wr),
    .wr_addr_i (nd_q[AW-1:0]),
    .wr_data_i (DW'(div_rem)),
    .rd_en_i   (stk_rd),
    .rd_addr_i (nd_m1[AW-1:0]),
    .rd_data_o (stk_data)
  );

  // One symbol lookup, shared by the alphabet scan and digit output
  assign sym_idx = (state_q == ST_SCAN) ? IDX_BITS'(scan_q) : IDX_BITS'(stk_data);
  assign sym     = alpha_q[sym_idx[IDX_BITS-1:3]][{sym_idx[2:0], 3'b000} +: SYM_BITS];
  assign sym_bad = !(sym inside {[SYM_LO:SYM_HI]}) || (sym == CHAR_PLUS) ||
                   (sym == CHAR_MINUS) || seen_q[sym[6:0]];

  function automatic logic [VALUE_BITS-1:0] in_bits_f(input logic [31:0] v);
    return v[VALUE_BITS-1:0];
  endfunction

  assign in_bits = in_bits_f(value_i);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    scan_d      = scan_q;
    radix_d     = radix_q;
    seen_d      = seen_q;
    nd_d        = nd_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    bad_base_d  = bad_base_q;
    is_last_d   = is_last_q;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_d   = in_bits[VALUE_BITS-1];
          mag_d   = in_bits[VALUE_BITS-1] ? (~in_bits + 1'b1) : in_bits;
          scan_d  = '0;
          seen_d  = '0;
          nd_d    = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Walk the alphabet one symbol per cycle until the terminator, a bad symbol or MAX_SYMBOLS entries
        if ((scan_q == RW'(MAX_SYMBOLS)) || (sym == CHAR_NONE)) begin
          if (scan_q < RW'(2)) begin
            out_char_d  = CHAR_NONE;
            bad_base_d  = 1'b1;
            is_last_d   = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_SHOW;
          end else begin
            radix_d = scan_q;
            state_d = ST_DSTART;
          end
        end else if (sym_bad) begin
          out_char_d  = CHAR_NONE;
          bad_base_d  = 1'b1;
          is_last_d   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_SHOW;
        end else begin
          seen_d[sym[6:0]] = 1'b1;
          scan_d           = scan_q + 1'b1;
        end
      end
      ST_DSTART: begin
        if (!div_stat.busy) begin
          div_start = 1'b1;
          state_d   = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        // Store the remainder as the next digit; continue on a nonzero quotient while the stack has room
        if (div_stat.done) begin
          mag_d = div_quo;
          nd_d  = nd_q + 1'b1;
          if ((div_quo == '0) || (nd_q == NW'(VALUE_BITS - 1))) begin
            if (neg_q) begin
              out_char_d  = CHAR_MINUS;
              bad_base_d  = 1'b0;
              is_last_d   = 1'b0;
              out_valid_d = 1'b1;
              state_d     = ST_SHOW;
            end else begin
              state_d = ST_READ;
            end
          end else begin
            state_d = ST_DSTART;
          end
        end
      end
      ST_READ: begin
        nd_d    = nd_m1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        out_char_d  = sym;
        bad_base_d  = 1'b0;
        is_last_d   = (nd_q == '0);
        out_valid_d = 1'b1;
        state_d     = ST_SHOW;
      end
      ST_SHOW: begin
        // Hold the result until taken
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = is_last_q ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      scan_q      <= '0;
      radix_q     <= '0;
      seen_q      <= '0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      bad_base_q  <= 1'b0;
      is_last_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      scan_q      <= scan_d;
      radix_q     <= radix_d;
      seen_q      <= seen_d;
      nd_q        <= nd_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      bad_base_q  <= bad_base_d;
      is_last_q   <= is_last_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign bad_base_o  = bad_base_q;
  assign is_last_o   = is_last_q;

endmodule : signed_radix_digit_emitter_core

`default_nettype wire
